// File: src/vn2s_pkg.sv
// vn2s_pkg: types, constants and helper functions for the smoothed 2d value noise block
// depends on nothing; used by every module of the block
`default_nettype none
package vn2s_pkg;

    localparam logic [31:0] HASH_MUL_SQ  = 32'd15731;
    localparam logic [31:0] HASH_ADD_SQ  = 32'd789221;
    localparam logic [31:0] HASH_ADD_OUT = 32'd1376312589;
    localparam logic [31:0] LAT_ONE      = 32'h8000_0000;
    localparam logic [31:0] ROW_STEP     = 32'd57;

    localparam longint unsigned PI_Q30  = 64'd3373259426;
    localparam longint          ONE_Q30 = 64'sd1073741824;

    // stage enables of one hash lane
    typedef struct packed {
        logic n;
        logic sq;
        logic t;
        logic g;
    } t_hash_en;

    // stage enables of the smoothing and interpolation back end
    typedef struct packed {
        logic smooth;
        logic mixx;
        logic mixy;
        logic outp;
    } t_mix_en;

    // (1 - cos(pi*k/2^bits))/2 in Q2.30, twelve taylor terms, k <= 2^bits/2
    function automatic longint half_versine_q30(input longint unsigned k,
                                                input int unsigned bits);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint          c;
        x    = (PI_Q30 * k) >> bits;
        x2   = (x * x) >> 30;
        term = ONE_Q30;
        c    = ONE_Q30;
        term = ((term * x2) >> 30) / 2;   c = c - longint'(term);
        term = ((term * x2) >> 30) / 12;  c = c + longint'(term);
        term = ((term * x2) >> 30) / 30;  c = c - longint'(term);
        term = ((term * x2) >> 30) / 56;  c = c + longint'(term);
        term = ((term * x2) >> 30) / 90;  c = c - longint'(term);
        term = ((term * x2) >> 30) / 132; c = c + longint'(term);
        term = ((term * x2) >> 30) / 182; c = c - longint'(term);
        term = ((term * x2) >> 30) / 240; c = c + longint'(term);
        term = ((term * x2) >> 30) / 306; c = c - longint'(term);
        term = ((term * x2) >> 30) / 380; c = c + longint'(term);
        term = ((term * x2) >> 30) / 462; c = c - longint'(term);
        term = ((term * x2) >> 30) / 552; c = c + longint'(term);
        return (ONE_Q30 - c) / 2;
    endfunction

    // blend table entry k in Q1.16
    function automatic logic [16:0] blend_entry(input int unsigned k,
                                                input int unsigned bits);
        longint unsigned size;
        longint          f;
        longint unsigned rnd;
        size = longint'(1) << bits;
        if (2 * longint'(k) <= size) begin
            f = half_versine_q30(longint'(k), bits);
        end else begin
            f = ONE_Q30 - half_versine_q30(size - longint'(k), bits);
        end
        if (f < 0) begin
            f = 0;
        end
        if (f > ONE_Q30) begin
            f = ONE_Q30;
        end
        rnd = (longint'(f) + 8192) >> 14;
        return rnd[16:0];
    endfunction

    // cosine blend step: (a*(65536-w) + b*w) >> 16, result stays below 2^32+1
    function automatic logic [32:0] cos_mix(input logic [32:0] a,
                                            input logic [32:0] b,
                                            input logic [16:0] w);
        logic [50:0] acc;
        acc = 51'(a) * 51'(17'd65536 - w) + 51'(b) * 51'(w);
        return acc[48:16];
    endfunction

endpackage
`default_nettype wire

// File: src/value_noise_2d_smoothed_top.sv
// value_noise_2d_smoothed_top: smoothed 2d value noise, ten stage pipeline
// throughput: one transaction per cycle while i_stall is low; the period multiply and the hash multiplies
//   each take a stage of their own, so every stage can be busy each cycle
// reset: synchronous active low i_rst_n clears the valid bits, seed to 0 and
//   inv_period to 1.0 (Q8.24); the pipeline payload is not reset
// depends on vn2s_pkg, vn2s_hash_lane, vn2s_blend, vn2s_interp
`default_nettype none
module value_noise_2d_smoothed_top #(
    parameter int FRAC_BITS        = 16,
    parameter int BLEND_TABLE_BITS = 8
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // apb style configuration port
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [2:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,
    // input channel
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic signed [31:0] i_x_coord,
    input  wire logic signed [31:0] i_y_coord,
    // output channel
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic [16:0]             o_noise_value
);
    import vn2s_pkg::*;

    localparam int NSTG = 10;
    localparam int SH   = FRAC_BITS + 24;

    // stage map
    //  0: coordinate times reciprocal period
    //  1: floor and fraction split, hash base x + 57*y + seed
    //  2: hash shift/xor, blend table read
    //  3: n*n, blend linear mix
    //  4: *15731 + 789221
    //  5: final hash multiply, lattice value 2^31 - v
    //  6: 3x3 smoothing of the four corners
    //  7: interpolation along x
    //  8: interpolation along y
    //  9: rounding to Q1.16, output register

    // configuration registers
    logic [31:0] r_seed;
    logic [31:0] r_inv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= '0;
            r_inv  <= 32'd16777216;
        end else if (psel && penable && pwrite) begin
            if (paddr[2]) begin
                r_inv <= pwdata;
            end else begin
                r_seed <= pwdata;
            end
        end
    end

    assign prdata = paddr[2] ? r_inv : r_seed;
    assign pready = 1'b1;

    // per stage valid bits and load enables; a stage loads when it is empty
    // or when the stage after it moves on, so bubbles close up under stall
    logic [NSTG-1:0] r_valid;
    logic [NSTG:0]   w_en;

    always_comb begin
        w_en[NSTG] = !i_stall;
        for (int s = NSTG - 1; s >= 0; s--) begin
            w_en[s] = !r_valid[s] || w_en[s+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (w_en[0]) begin
                r_valid[0] <= i_valid;
            end
            for (int s = 1; s < NSTG; s++) begin
                if (w_en[s]) begin
                    r_valid[s] <= r_valid[s-1];
                end
            end
        end
    end

    assign o_stall = !w_en[0];
    assign o_valid = r_valid[NSTG-1];

    // stage 0: signed coordinate times unsigned reciprocal
    logic signed [32:0] w_inv_s;
    logic signed [63:0] n_px;
    logic signed [63:0] n_py;
    logic signed [63:0] r_px;
    logic signed [63:0] r_py;

    always_comb begin
        w_inv_s = {1'b0, r_inv};
        n_px    = i_x_coord * w_inv_s;
        n_py    = i_y_coord * w_inv_s;
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_px <= n_px;
            r_py <= n_py;
        end
    end

    // stage 1: true floor of the scaled coordinate, wrapped to 32 bits
    logic signed [63:0] w_cx_full;
    logic signed [63:0] w_cy_full;
    logic [31:0] w_cx;
    logic [31:0] w_cy;
    logic [31:0] n_n0;
    logic [31:0] r_n0;
    logic [15:0] r_fx;
    logic [15:0] r_fy;

    always_comb begin
        w_cx_full = r_px >>> SH;
        w_cy_full = r_py >>> SH;
        w_cx      = w_cx_full[31:0];
        w_cy      = w_cy_full[31:0];
        n_n0      = w_cx + w_cy * ROW_STEP + r_seed;
    end

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r_n0 <= n_n0;
            r_fx <= r_px[FRAC_BITS+23:FRAC_BITS+8];
            r_fy <= r_py[FRAC_BITS+23:FRAC_BITS+8];
        end
    end

    // stages 2..5: sixteen hash lanes over the 4x4 window around the cell
    t_hash_en    w_hash_en;
    logic [31:0] w_lat [16];

    assign w_hash_en = '{n: w_en[2], sq: w_en[3], t: w_en[4], g: w_en[5]};

    for (genvar j = 0; j < 4; j++) begin : g_row
        for (genvar i = 0; i < 4; i++) begin : g_col
            // window point (i-1, j-1) relative to the cell
            localparam logic [31:0] OFFSET = 32'((i - 1) + 57 * (j - 1));
            vn2s_hash_lane u_lane (
                .i_clk    (i_clk),
                .i_en     (w_hash_en),
                .i_n0     (r_n0),
                .i_offset (OFFSET),
                .o_lat    (w_lat[j*4 + i])
            );
        end
    end

    // stages 2..3: blend weights for x and y
    logic [16:0] w_wx3;
    logic [16:0] w_wy3;

    vn2s_blend #(.BLEND_TABLE_BITS(BLEND_TABLE_BITS)) u_blend_x (
        .i_clk    (i_clk),
        .i_en_rom (w_en[2]),
        .i_en_mix (w_en[3]),
        .i_frac   (r_fx),
        .o_weight (w_wx3)
    );

    vn2s_blend #(.BLEND_TABLE_BITS(BLEND_TABLE_BITS)) u_blend_y (
        .i_clk    (i_clk),
        .i_en_rom (w_en[2]),
        .i_en_mix (w_en[3]),
        .i_frac   (r_fy),
        .o_weight (w_wy3)
    );

    // weights ride along until the interpolation stage that uses them
    logic [16:0] r_wx4, r_wx5, r_wx6;
    logic [16:0] r_wy4, r_wy5, r_wy6, r_wy7;

    always_ff @(posedge i_clk) begin
        if (w_en[4]) begin
            r_wx4 <= w_wx3;
            r_wy4 <= w_wy3;
        end
        if (w_en[5]) begin
            r_wx5 <= r_wx4;
            r_wy5 <= r_wy4;
        end
        if (w_en[6]) begin
            r_wx6 <= r_wx5;
            r_wy6 <= r_wy5;
        end
        if (w_en[7]) begin
            r_wy7 <= r_wy6;
        end
    end

    // stages 6..9: smoothing, interpolation, rounding
    t_mix_en w_mix_en;

    assign w_mix_en = '{smooth: w_en[6], mixx: w_en[7], mixy: w_en[8], outp: w_en[9]};

    vn2s_interp u_interp (
        .i_clk         (i_clk),
        .i_en          (w_mix_en),
        .i_lat         (w_lat),
        .i_wx          (r_wx6),
        .i_wy          (r_wy7),
        .o_noise_value (o_noise_value)
    );
endmodule
`default_nettype wire

// File: src/vn2s_hash_lane.sv
// vn2s_hash_lane: one lattice point hash, four register stages
// depends on vn2s_pkg
`default_nettype none
module vn2s_hash_lane (
    input  wire logic              i_clk,
    input  wire vn2s_pkg::t_hash_en i_en,
    input  wire logic [31:0]       i_n0,
    input  wire logic [31:0]       i_offset,
    output logic [31:0]            o_lat
);
    import vn2s_pkg::*;

    logic [31:0] n_pos;
    logic [31:0] n_n;
    logic [31:0] n_sq;
    logic [31:0] n_t;
    logic [31:0] n_prod;
    logic [30:0] n_v;
    logic [31:0] r_n;
    logic [31:0] r_n3;
    logic [31:0] r_n4;
    logic [31:0] r_sq;
    logic [31:0] r_t;
    logic [31:0] r_lat;

    always_comb begin
        n_pos  = i_n0 + i_offset;
        n_n    = (n_pos << 13) ^ n_pos;
        n_sq   = r_n * r_n;
        n_t    = r_sq * HASH_MUL_SQ + HASH_ADD_SQ;
        n_prod = r_n4 * r_t + HASH_ADD_OUT;
        n_v    = n_prod[30:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en.n) begin
            r_n <= n_n;
        end
        if (i_en.sq) begin
            r_sq <= n_sq;
            r_n3 <= r_n;
        end
        if (i_en.t) begin
            r_t  <= n_t;
            r_n4 <= r_n3;
        end
        if (i_en.g) begin
            r_lat <= LAT_ONE - {1'b0, n_v};
        end
    end

    assign o_lat = r_lat;
endmodule
`default_nettype wire

// File: src/vn2s_blend.sv
// vn2s_blend: cosine blend weight from a constant table and a linear mix
// depends on vn2s_pkg
`default_nettype none
module vn2s_blend #(
    parameter int BLEND_TABLE_BITS = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_en_rom,
    input  wire logic        i_en_mix,
    input  wire logic [15:0] i_frac,
    output logic [16:0]      o_weight
);
    import vn2s_pkg::*;

    localparam int SIZE = 1 << BLEND_TABLE_BITS;
    localparam int SH   = 16 - BLEND_TABLE_BITS;
    localparam logic [SH:0] SPAN = (SH + 1)'(1 << SH);
    localparam int MW   = 17 + SH + 1;

    logic [16:0] w_rom [0:SIZE];
    logic [BLEND_TABLE_BITS-1:0] n_idx;
    logic [BLEND_TABLE_BITS:0]   n_idx0;
    logic [BLEND_TABLE_BITS:0]   n_idx1;
    logic [16:0]  r_t0;
    logic [16:0]  r_t1;
    logic [SH-1:0] r_r;
    logic [MW-1:0] n_mix;
    logic [16:0]  r_w;

    for (genvar k = 0; k <= SIZE; k++) begin : g_rom
        assign w_rom[k] = blend_entry(k, BLEND_TABLE_BITS);
    end

    always_comb begin
        n_idx  = i_frac[15:SH];
        n_idx0 = {1'b0, n_idx};
        n_idx1 = n_idx0 + 1'b1;
        n_mix  = MW'(r_t0) * MW'(SPAN - {1'b0, r_r}) + MW'(r_t1) * MW'(r_r);
    end

    always_ff @(posedge i_clk) begin
        if (i_en_rom) begin
            r_t0 <= w_rom[n_idx0];
            r_t1 <= w_rom[n_idx1];
            r_r  <= i_frac[SH-1:0];
        end
        if (i_en_mix) begin
            r_w <= n_mix[SH+16:SH];
        end
    end

    assign o_weight = r_w;
endmodule
`default_nettype wire

// File: src/vn2s_interp.sv
// vn2s_interp: 3x3 corner smoothing, cosine interpolation along x and y, rounding
// depends on vn2s_pkg
`default_nettype none
module vn2s_interp (
    input  wire logic              i_clk,
    input  wire vn2s_pkg::t_mix_en i_en,
    input  wire logic [31:0]       i_lat [16],
    input  wire logic [16:0]       i_wx,
    input  wire logic [16:0]       i_wy,
    output logic [16:0]            o_noise_value
);
    import vn2s_pkg::*;

    logic [35:0] n_sum [4];
    logic [32:0] r_corner [4];
    logic [32:0] r_top;
    logic [32:0] r_bot;
    logic [32:0] r_res;
    logic [33:0] n_rnd;
    logic [16:0] r_out;

    // corner c sits at row c/2 + 1, column c%2 + 1 of the 4x4 lattice window
    always_comb begin
        for (int c = 0; c < 4; c++) begin
            n_sum[c] = 36'(i_lat[(c/2)*4 + (c%2)])
                     + 36'(i_lat[(c/2)*4 + (c%2) + 2])
                     + 36'(i_lat[(c/2 + 2)*4 + (c%2)])
                     + 36'(i_lat[(c/2 + 2)*4 + (c%2) + 2])
                     + ((36'(i_lat[(c/2)*4 + (c%2) + 1])
                       + 36'(i_lat[(c/2 + 2)*4 + (c%2) + 1])
                       + 36'(i_lat[(c/2 + 1)*4 + (c%2)])
                       + 36'(i_lat[(c/2 + 1)*4 + (c%2) + 2])) << 1)
                     + (36'(i_lat[(c/2 + 1)*4 + (c%2) + 1]) << 2);
        end
        n_rnd = {1'b0, r_res} + 34'd32768;
    end

    always_ff @(posedge i_clk) begin
        if (i_en.smooth) begin
            for (int c = 0; c < 4; c++) begin
                r_corner[c] <= n_sum[c][35:3];
            end
        end
        if (i_en.mixx) begin
            r_top <= cos_mix(r_corner[0], r_corner[1], i_wx);
            r_bot <= cos_mix(r_corner[2], r_corner[3], i_wx);
        end
        if (i_en.mixy) begin
            r_res <= cos_mix(r_top, r_bot, i_wy);
        end
        if (i_en.outp) begin
            r_out <= n_rnd[32:16];
        end
    end

    assign o_noise_value = r_out;
endmodule
`default_nettype wire

// File: sim/value_noise_2d_smoothed_top_test.sv
// value_noise_2d_smoothed_top_test: self-checking testbench for the smoothed 2d value noise block
// depends on value_noise_2d_smoothed_top (register map only through the apb port)
`default_nettype none
module value_noise_2d_smoothed_top_test;

    localparam int FRAC_BITS        = 16;
    localparam int BLEND_TABLE_BITS = 8;
    localparam int BLEND_SIZE       = 1 << BLEND_TABLE_BITS;
    localparam int PIPE_LATENCY     = 10;
    localparam longint CYCLE_LIMIT  = 400000;

    // register byte addresses
    localparam logic [2:0] REG_SEED       = 3'd0;
    localparam logic [2:0] REG_INV_PERIOD = 3'd4;

    // idle modes
    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} t_idle_mode;

    logic               i_clk;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [2:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    logic               i_valid;
    logic               o_stall;
    logic signed [31:0] i_x_coord;
    logic signed [31:0] i_y_coord;
    logic               o_valid;
    logic               i_stall;
    logic [16:0]        o_noise_value;

    value_noise_2d_smoothed_top #(
        .FRAC_BITS(FRAC_BITS),
        .BLEND_TABLE_BITS(BLEND_TABLE_BITS)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_x_coord(i_x_coord),
        .i_y_coord(i_y_coord),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_noise_value(o_noise_value)
    );

    // predictor copy of the registers and the cosine table
    logic [31:0] noise_seed;
    logic [31:0] noise_inv_period;
    logic [16:0] cos_table [0:BLEND_SIZE];

    logic [16:0] noise_expected [$];
    int          error_count;
    longint      cycle_count;
    t_idle_mode  idle_mode;
    int          recv_hold;     // long receiver hold-off, in cycles

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // timeout guard
    initial begin
        cycle_count = 0;
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // idle percentage of the current phase
    function automatic int idle_pct();
        return (idle_mode == IDLE_BOTH) ? 16 : 76;
    endfunction

    // half versine in Q2.30 by truncated taylor series
    function automatic longint cos_half_q30(longint unsigned k);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint          c;
        x    = (64'd3373259426 * k) >> BLEND_TABLE_BITS;
        x2   = (x * x) >> 30;
        term = 64'd1073741824;
        c    = 64'sd1073741824;
        for (int n = 0; n < 12; n++) begin
            term = ((term * x2) >> 30) / longint'((2 * n + 1) * (2 * n + 2));
            if (n % 2 == 1) c += longint'(term);
            else            c -= longint'(term);
        end
        return (64'sd1073741824 - c) / 2;
    endfunction

    function automatic void build_cos_table();
        longint f;
        for (int k = 0; k <= BLEND_SIZE; k++) begin
            if (2 * k <= BLEND_SIZE) f = cos_half_q30(k);
            else f = 64'sd1073741824 - cos_half_q30(BLEND_SIZE - k);
            if (f < 0) f = 0;
            if (f > 64'sd1073741824) f = 64'sd1073741824;
            cos_table[k] = 17'((f + 8192) >>> 14);
        end
    endfunction

    // scale a coordinate into lattice cell and 16 bit fraction
    function automatic void cell_split(logic [31:0] coord, output logic [31:0] lat_cell,
                                       output logic [15:0] frac);
        logic signed [63:0] prod;
        prod = 64'($signed(coord)) * $signed({32'd0, noise_inv_period});
        lat_cell = 32'(prod >>> (FRAC_BITS + 24));
        frac = 16'(prod >> (FRAC_BITS + 8));
    endfunction

    function automatic logic [32:0] lattice_value(logic [31:0] x, logic [31:0] y);
        logic [31:0] n;
        logic [31:0] v;
        n = x + y * 32'd57 + noise_seed;
        n = (n << 13) ^ n;
        v = (n * (n * n * 32'd15731 + 32'd789221) + 32'd1376312589) & 32'h7fff_ffff;
        return 33'h0_8000_0000 - 33'(v);
    endfunction

    function automatic logic [16:0] blend_weight(logic [15:0] frac);
        localparam int SH = 16 - BLEND_TABLE_BITS;
        int unsigned idx;
        longint unsigned r;
        longint unsigned mix;
        idx = frac >> SH;
        r   = frac & ((1 << SH) - 1);
        mix = longint'(cos_table[idx]) * ((longint'(1) << SH) - r)
            + longint'(cos_table[idx + 1]) * r;
        return 17'(mix >> SH);
    endfunction

    function automatic logic [32:0] blend_mix(logic [32:0] a, logic [32:0] b, logic [16:0] w);
        logic [63:0] acc;
        acc = 64'(a) * (64'd65536 - 64'(w)) + 64'(b) * 64'(w);
        return 33'(acc >> 16);
    endfunction

    function automatic logic [16:0] noise_predict(logic [31:0] xc, logic [31:0] yc);
        logic [31:0] cx, cy;
        logic [15:0] fx, fy;
        logic [32:0] g [0:3][0:3];
        logic [32:0] corner [0:1][0:1];
        logic [63:0] s;
        logic [32:0] top_row, bot_row, res;
        cell_split(xc, cx, fx);
        cell_split(yc, cy, fy);
        for (int j = 0; j < 4; j++)
            for (int i = 0; i < 4; i++)
                g[j][i] = lattice_value(cx + i - 1, cy + j - 1);
        for (int j = 0; j < 2; j++)
            for (int i = 0; i < 2; i++) begin
                s = 64'(g[j][i]) + g[j][i+2] + g[j+2][i] + g[j+2][i+2];
                s += 2 * (64'(g[j][i+1]) + g[j+2][i+1] + g[j+1][i] + g[j+1][i+2]);
                s += 4 * 64'(g[j+1][i+1]);
                corner[j][i] = 33'(s >> 3);
            end
        top_row = blend_mix(corner[0][0], corner[0][1], blend_weight(fx));
        bot_row = blend_mix(corner[1][0], corner[1][1], blend_weight(fx));
        res = blend_mix(top_row, bot_row, blend_weight(fy));
        return 17'((64'(res) + 32768) >> 16);
    endfunction

    // apb write, setup then access
    task automatic reg_write(logic [2:0] addr, logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == REG_SEED) noise_seed = data;
        else if (addr == REG_INV_PERIOD) noise_inv_period = data;
    endtask

    // send one coordinate transaction, with idle cycles first in the IDLE_SEND and IDLE_BOTH phases
    task automatic send_sample(logic [31:0] xc, logic [31:0] yc);
        if (idle_mode == IDLE_SEND || idle_mode == IDLE_BOTH) begin
            while ($urandom_range(99) < idle_pct()) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_valid   <= 1'b1;
        i_x_coord <= xc;
        i_y_coord <= yc;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        noise_expected.push_back(noise_predict(xc, yc));
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (noise_expected.size() != 0) @(posedge i_clk);
        repeat (PIPE_LATENCY + 4) @(posedge i_clk);
    endtask

    // receiver stall driver
    always @(posedge i_clk) begin
        if (recv_hold > 0) begin
            recv_hold <= recv_hold - 1;
            i_stall   <= 1'b1;
        end else if (idle_mode == IDLE_RECV || idle_mode == IDLE_BOTH) begin
            i_stall <= ($urandom_range(99) < idle_pct());
        end else begin
            i_stall <= 1'b0;
        end
    end

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (noise_expected.size() == 0) begin
                $error("noise_value: unexpected transaction, actual %0d", o_noise_value);
                error_count++;
            end else begin
                logic [16:0] want;
                want = noise_expected.pop_front();
                if (want !== o_noise_value) begin
                    $error("noise_value: expected %0d actual %0d", want, o_noise_value);
                    error_count++;
                end
            end
        end
    end

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(3))
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000);
            2: return {$urandom_range(0, 1) ? 16'hffff : 16'h0000, 16'($urandom)};
            default: return 32'($urandom_range(0, 32'h00ff_ffff));
        endcase
    endfunction

    // extremes of the coordinates, zero reciprocal period and huge wrapping cells
    task automatic test_directed();
        logic [31:0] edge_vals [0:5];
        edge_vals = '{32'h0, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff,
                      32'h0000_8000, 32'h0001_0000};
        idle_mode = IDLE_NONE;
        for (int k = 0; k < 6; k++) send_sample(edge_vals[k], edge_vals[5 - k]);
        wait_drained();
        reg_write(REG_INV_PERIOD, 32'hffff_ffff);
        reg_write(REG_SEED, 32'h7fff_ffff);
        for (int k = 0; k < 6; k++) send_sample(edge_vals[k], edge_vals[k]);
        wait_drained();
        reg_write(REG_INV_PERIOD, 32'h0);
        reg_write(REG_SEED, 32'h8000_0000);
        send_sample(32'h1234_5678, 32'h8765_4321);
        send_sample(32'h8000_0000, 32'h7fff_ffff);
        wait_drained();
    endtask

    task automatic test_random_phase(t_idle_mode mode, int count);
        idle_mode = mode;
        reg_write(REG_SEED, $urandom);
        case ($urandom_range(3))
            0: reg_write(REG_INV_PERIOD, 32'h0100_0000);
            1: reg_write(REG_INV_PERIOD, $urandom);
            2: reg_write(REG_INV_PERIOD, $urandom_range(0, 32'h0400_0000));
            default: reg_write(REG_INV_PERIOD, 32'hffff_ffff);
        endcase
        for (int k = 0; k < count; k++) send_sample(rand_coord(), rand_coord());
        wait_drained();
    endtask

    // long receiver hold-off so the pipeline backs up and stalls its input
    task automatic test_backpressure();
        idle_mode = IDLE_NONE;
        recv_hold = 60;
        for (int k = 0; k < 80; k++) send_sample(rand_coord(), rand_coord());
        wait_drained();
    endtask

    initial begin
        error_count = 0;
        idle_mode   = IDLE_NONE;
        recv_hold   = 0;
        noise_seed       = 32'd0;
        noise_inv_period = 32'h0100_0000;
        build_cos_table();
        i_rst_n   = 1'b0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        i_valid   = 1'b0;
        i_stall   = 1'b0;
        i_x_coord = '0;
        i_y_coord = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset defaults first, before any write
        send_sample(32'h0001_8000, 32'hfffe_4000);
        wait_drained();
        test_directed();
        test_random_phase(IDLE_NONE, 300);
        test_random_phase(IDLE_SEND, 250);
        test_random_phase(IDLE_RECV, 250);
        test_random_phase(IDLE_BOTH, 250);
        test_backpressure();
        test_random_phase(IDLE_NONE, 100);

        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
`default_nettype wire
